@@ rtl/ida_pkg.sv @@
// shared types, constants and helper functions for the id allocator with nearest pick
package ida_pkg;

    localparam int ID_COUNT_DEF   = 256;
    localparam int MAX_RADIUS_DEF = 63;

    // field widths
    localparam int ID_W    = 8;
    localparam int COORD_W = 13;
    localparam int VIEW_W  = 14;
    localparam int RAD_W   = 6;
    localparam int XID_W   = 9;
    localparam int PIX_W   = 32;
    localparam int WIN_W   = 7;
    localparam int DIST_W  = 16;
    localparam int CLIP_W  = 16;
    localparam int ACT_W   = 2;
    localparam int IDX_W   = 2;

    // map rows
    localparam int ROW_BITS  = 16;
    localparam int ROW_SHIFT = 4;

    // actions
    localparam logic [ACT_W-1:0] ACT_ALLOC = 2'd0;
    localparam logic [ACT_W-1:0] ACT_FREE  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_PICK  = 2'd2;
    localparam logic [ACT_W-1:0] ACT_PIXEL = 2'd3;

    // register indexes
    localparam logic [IDX_W-1:0] REG_VIEW_LEFT   = 2'd0;
    localparam logic [IDX_W-1:0] REG_VIEW_BOTTOM = 2'd1;
    localparam logic [IDX_W-1:0] REG_VIEW_WIDTH  = 2'd2;
    localparam logic [IDX_W-1:0] REG_VIEW_HEIGHT = 2'd3;

    localparam logic [VIEW_W-1:0] VIEW_WIDTH_RST  = 14'd1920;
    localparam logic [VIEW_W-1:0] VIEW_HEIGHT_RST = 14'd1080;

    // input word layout
    localparam int S_DATA_W = 88;
    localparam int S_ID_LO  = 0;
    localparam int S_PX_LO  = 8;
    localparam int S_PY_LO  = 21;
    localparam int S_RAD_LO = 34;
    localparam int S_XID_LO = 40;
    localparam int S_PIX_LO = 49;

    // output word layout
    localparam int M_DATA_W  = 56;
    localparam int M_USED_W  = 49;
    localparam int M_SUCCESS = 8;
    localparam int M_WX_LO   = 9;
    localparam int M_WY_LO   = 22;
    localparam int M_WW_LO   = 35;
    localparam int M_WH_LO   = 42;

    typedef logic [ROW_BITS-1:0] row_t;

    typedef struct packed {
        logic               empty;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [WIN_W-1:0]   w;
        logic [WIN_W-1:0]   h;
    } win_t;

    // {found, index of lowest set bit}
    function automatic logic [ROW_SHIFT:0] lowest_set(input row_t v);
        logic [ROW_SHIFT-1:0] idx;
        idx = '0;
        for (int i = ROW_BITS - 1; i >= 0; i--) begin
            if (v[i])
                idx = ROW_SHIFT'(i);
        end
        return {|v, idx};
    endfunction

    // bits of a row whose ids may be handed out
    function automatic row_t alloc_mask(input int row, input int id_count);
        row_t m;
        int   id;
        m = '0;
        for (int b = 0; b < ROW_BITS; b++) begin
            id   = row * ROW_BITS + b;
            m[b] = (id >= 1) && (id <= id_count - 2);
        end
        return m;
    endfunction

    // rows holding at least one id that may be handed out
    function automatic row_t allocable_rows(input int id_count);
        row_t r;
        r = '0;
        for (int row = 0; row < ROW_BITS; row++) begin
            r[row] = |alloc_mask(row, id_count);
        end
        return r;
    endfunction

endpackage

@@ rtl/ida_map.sv @@
// allocation map ram, one row of ids per entry, with per-row valid flags
module ida_map
    import ida_pkg::*;
#(
    parameter int ROWS   = 16,
    parameter int ROW_AW = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rd_en,
    input  logic [ROW_AW-1:0] rd_addr,
    output row_t              rd_data,
    input  logic              wr_en,
    input  logic [ROW_AW-1:0] wr_addr,
    input  row_t              wr_data
);

    row_t            mem [ROWS];
    row_t            rd_data_reg;
    logic            rd_valid_reg;
    logic [ROWS-1:0] valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    // a row never written reads as all clear
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
                valid_reg[wr_addr] <= 1'b1;
            if (rd_en)
                rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

@@ rtl/ida_clip.sv @@
// clips the square pick window around a point to the viewport
module ida_clip
    import ida_pkg::*;
#(
    parameter int MAX_RADIUS = MAX_RADIUS_DEF
) (
    input  logic [COORD_W-1:0] point_x,
    input  logic [COORD_W-1:0] point_y,
    input  logic [RAD_W-1:0]   radius,
    input  logic [COORD_W-1:0] view_left,
    input  logic [COORD_W-1:0] view_bottom,
    input  logic [VIEW_W-1:0]  view_width,
    input  logic [VIEW_W-1:0]  view_height,
    output win_t               win
);

    localparam logic [RAD_W-1:0] R_MAX = RAD_W'(MAX_RADIUS);

    logic [RAD_W-1:0]         r;
    logic signed [CLIP_W-1:0] lo_x, hi_x, lo_y, hi_y;
    logic signed [CLIP_W-1:0] lft, rgt, bot, ceil_y;
    logic signed [CLIP_W-1:0] left_x, right_x, low_y, high_y;
    logic signed [CLIP_W-1:0] w, h;

    assign r = (radius > R_MAX) ? R_MAX : radius;

    assign lo_x = $signed({3'b0, point_x}) - $signed({10'b0, r});
    assign hi_x = $signed({3'b0, point_x}) + $signed({10'b0, r}) + 16'sd1;
    assign lo_y = $signed({3'b0, point_y}) - $signed({10'b0, r});
    assign hi_y = $signed({3'b0, point_y}) + $signed({10'b0, r}) + 16'sd1;

    // right and top edges sit at origin plus size
    assign lft    = $signed({3'b0, view_left});
    assign rgt    = $signed({3'b0, view_left}) + $signed({2'b0, view_width});
    assign bot    = $signed({3'b0, view_bottom});
    assign ceil_y = $signed({3'b0, view_bottom}) + $signed({2'b0, view_height});

    assign left_x  = (lo_x < lft) ? lft : lo_x;
    assign right_x = (hi_x > rgt) ? rgt : hi_x;
    assign low_y   = (lo_y < bot) ? bot : lo_y;
    assign high_y  = (hi_y > ceil_y) ? ceil_y : hi_y;

    assign w = right_x - left_x;
    assign h = high_y - low_y;

    assign win.empty = (w <= 16'sd0) || (h <= 16'sd0);
    assign win.x     = left_x[COORD_W-1:0];
    assign win.y     = low_y[COORD_W-1:0];
    assign win.w     = w[WIN_W-1:0];
    assign win.h     = h[WIN_W-1:0];

endmodule

@@ rtl/id_allocator_nearest_pick.sv @@
// top level: selection id allocator with nearest-hit pick over a streamed window
//
//  channel   dir   handshake                 carries
//  cfg       in    cfg_we                    viewport register writes, no read-back
//  s_*       in    s_tvalid / s_tready       one command or window pixel word
//  m_*       out   m_tvalid / m_tready       allocate, free, pick start and pick answer
//
//  each accepted word is handled in an accept step and an execute step: the accept cycle issues the map row read,
//  the execute step does the read-modify-write of that row and loads the result register
//  the registered read of the map ram sets these steps, and only one word is in flight at a time
//  a word whose result meets a full, untaken result register waits there until it drains
//  reset marks every map row not written, so the map reads as all free at once
//  the viewport registers reset to left 0, bottom 0, width 1920, height 1080
module id_allocator_nearest_pick
    import ida_pkg::*;
#(
    parameter int ID_COUNT   = ID_COUNT_DEF,
    parameter int MAX_RADIUS = MAX_RADIUS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    // configuration write port
    input  logic                cfg_we,
    input  logic [IDX_W-1:0]    cfg_index,
    input  logic [VIEW_W-1:0]   cfg_wdata,
    // input words
    input  logic                s_tvalid,
    output logic                s_tready,
    // id_to_free, point_x, point_y, radius, excluded_id, pixel_word, zero fill
    input  logic [S_DATA_W-1:0] s_tdata,
    // action
    input  logic [ACT_W-1:0]    s_tuser,
    // result words
    output logic                m_tvalid,
    input  logic                m_tready,
    // result_id, success, window_x, window_y, window_w, window_h, zero fill
    output logic [M_DATA_W-1:0] m_tdata,
    // pick_done
    output logic                m_tlast
);

    localparam int ROWS   = (ID_COUNT + ROW_BITS - 1) / ROW_BITS;
    localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CNT_W  = $clog2(2 * MAX_RADIUS + 2);
    localparam logic [ID_W:0] ID_LIMIT = (ID_W + 1)'(ID_COUNT);
    localparam row_t ROW_OK = allocable_rows(ID_COUNT);

    function automatic logic id_ok(input logic [ID_W-1:0] id);
        return {1'b0, id} < ID_LIMIT;
    endfunction

    function automatic logic [ROW_AW-1:0] row_of(input logic [ID_W-1:0] id);
        return id_ok(id) ? id[ROW_SHIFT +: ROW_AW] : '0;
    endfunction

    // viewport registers
    logic [COORD_W-1:0] view_left_reg, view_bottom_reg;
    logic [VIEW_W-1:0]  view_width_reg, view_height_reg;

    // captured word
    logic                busy_reg, busy_next;
    logic [ACT_W-1:0]    act_reg;
    logic [ID_W-1:0]     id_reg;
    logic [COORD_W-1:0]  px_reg, py_reg;
    logic [RAD_W-1:0]    rad_reg;
    logic [XID_W-1:0]    xid_reg;
    logic [ID_W-1:0]     pix_id_reg;
    logic [ROW_AW-1:0]   alloc_row_reg;
    logic                alloc_found_reg;
    logic [DIST_W-1:0]   sq_i_reg, sq_j_reg;

    // pick search state
    logic                active_reg, active_next;
    logic [CNT_W-1:0]    win_w_reg, win_w_next;
    logic [CNT_W-1:0]    win_h_reg, win_h_next;
    logic [CNT_W-1:0]    row_reg, row_next;
    logic [CNT_W-1:0]    col_reg, col_next;
    logic [DIST_W-1:0]   best_dist_reg, best_dist_next;
    logic [ID_W-1:0]     best_id_reg, best_id_next;
    logic [XID_W-1:0]    skip_reg, skip_next;
    // rows with every allocatable id taken
    logic [ROWS-1:0]     full_reg, full_next;

    // result register
    logic                m_valid_reg;
    logic [M_DATA_W-1:0] out_data_reg;
    logic                out_last_reg;

    logic                acc;
    logic [ID_W-1:0]     id_in, pix_in;
    row_t                cand;
    logic [ROW_SHIFT:0]  cand_pick;
    logic                rd_en;
    logic [ROW_AW-1:0]   rd_addr;
    row_t                rdata;
    logic                wr_req;
    logic [ROW_AW-1:0]   wr_addr;
    row_t                wr_data;

    logic signed [CNT_W+1:0]   di, dj;
    logic signed [2*CNT_W+3:0] di_sq, dj_sq;

    win_t                win;
    row_t                amask;
    logic [ROW_SHIFT:0]  alloc_pick;
    logic                free_hit;
    logic [DIST_W-1:0]   pix_dist;
    logic                hit;
    logic                col_last, row_last;
    logic                out_free;
    logic                has_res;
    logic                exec_go;
    logic [ID_W-1:0]     res_id;
    logic                res_ok;
    logic                res_last;
    win_t                res_win;

    assign s_tready = !busy_reg;
    assign acc      = s_tvalid && !busy_reg;
    assign id_in    = s_tdata[S_ID_LO +: ID_W];
    assign pix_in   = s_tdata[S_PIX_LO +: ID_W];

    // lowest row that still has a free allocatable id
    assign cand      = ROW_OK & row_t'(~full_reg);
    assign cand_pick = lowest_set(cand);

    // map row read issued in the accept cycle
    assign rd_en = acc;
    always_comb
    begin
        unique case (s_tuser)
            ACT_ALLOC: rd_addr = cand_pick[ROW_AW-1:0];
            ACT_FREE:  rd_addr = row_of(id_in);
            ACT_PIXEL: rd_addr = row_of(pix_in);
            default:   rd_addr = '0;
        endcase
    end

    // doubled offsets from the window centre, squared ahead of the compare
    assign di    = $signed({1'b0, row_reg, 1'b0}) - $signed({2'b0, win_h_reg});
    assign dj    = $signed({1'b0, col_reg, 1'b0}) - $signed({2'b0, win_w_reg});
    assign di_sq = di * di;
    assign dj_sq = dj * dj;

    ida_map #(
        .ROWS   (ROWS),
        .ROW_AW (ROW_AW)
    ) u_map (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rdata),
        .wr_en   (wr_req && exec_go),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    ida_clip #(
        .MAX_RADIUS (MAX_RADIUS)
    ) u_clip (
        .point_x     (px_reg),
        .point_y     (py_reg),
        .radius      (rad_reg),
        .view_left   (view_left_reg),
        .view_bottom (view_bottom_reg),
        .view_width  (view_width_reg),
        .view_height (view_height_reg),
        .win         (win)
    );

    assign amask      = alloc_mask(int'(alloc_row_reg), ID_COUNT);
    assign alloc_pick = lowest_set(~rdata & amask);
    assign free_hit   = id_ok(id_reg) && rdata[id_reg[ROW_SHIFT-1:0]];

    assign pix_dist = sq_i_reg + sq_j_reg;
    assign hit  = id_ok(pix_id_reg) && rdata[pix_id_reg[ROW_SHIFT-1:0]]
                  && ({1'b0, pix_id_reg} != skip_reg) && (pix_dist < best_dist_reg);

    assign col_last = (col_reg == win_w_reg - CNT_W'(1));
    assign row_last = (row_reg == win_h_reg - CNT_W'(1));
    assign out_free = !m_valid_reg || m_tready;

    // execute: read-modify-write of the fetched map row and search update
    always_comb
    begin
        active_next    = active_reg;
        win_w_next     = win_w_reg;
        win_h_next     = win_h_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        best_dist_next = best_dist_reg;
        best_id_next   = best_id_reg;
        skip_next      = skip_reg;
        full_next      = full_reg;
        wr_req         = 1'b0;
        wr_addr        = '0;
        wr_data        = rdata;
        has_res        = 1'b0;
        res_id         = '0;
        res_ok         = 1'b0;
        res_last       = 1'b0;
        res_win        = '0;
        if (busy_reg)
        begin
            unique case (act_reg)
                ACT_ALLOC:
                begin
                    has_res = 1'b1;
                    if (alloc_found_reg)
                    begin
                        wr_req  = 1'b1;
                        wr_addr = alloc_row_reg;
                        wr_data = rdata | (row_t'(1) << alloc_pick[ROW_SHIFT-1:0]);
                        full_next[alloc_row_reg] = &(wr_data | ~amask);
                        res_id  = ID_W'({alloc_row_reg, alloc_pick[ROW_SHIFT-1:0]});
                        res_ok  = 1'b1;
                    end
                end
                ACT_FREE:
                begin
                    has_res = 1'b1;
                    if (free_hit)
                    begin
                        wr_req  = 1'b1;
                        wr_addr = row_of(id_reg);
                        wr_data = rdata & ~(row_t'(1) << id_reg[ROW_SHIFT-1:0]);
                        full_next[row_of(id_reg)] = 1'b0;
                        res_ok  = 1'b1;
                    end
                end
                ACT_PICK:
                begin
                    has_res  = 1'b1;
                    row_next = '0;
                    col_next = '0;
                    if (win.empty)
                    begin
                        active_next = 1'b0;
                        win_w_next  = '0;
                        win_h_next  = '0;
                        res_last    = 1'b1;
                    end
                    else
                    begin
                        // a new pick restarts over one still running
                        active_next    = 1'b1;
                        win_w_next     = win.w[CNT_W-1:0];
                        win_h_next     = win.h[CNT_W-1:0];
                        best_dist_next = '1;
                        best_id_next   = '0;
                        skip_next      = xid_reg;
                        res_win        = win;
                        res_win.empty  = 1'b0;
                    end
                end
                ACT_PIXEL:
                begin
                    // a pixel with no pick running is dropped
                    if (active_reg)
                    begin
                        if (hit)
                        begin
                            best_dist_next = pix_dist;
                            best_id_next   = pix_id_reg;
                        end
                        if (col_last)
                        begin
                            col_next = '0;
                            row_next = row_reg + CNT_W'(1);
                        end
                        else
                        begin
                            col_next = col_reg + CNT_W'(1);
                        end
                        if (col_last && row_last)
                        begin
                            has_res     = 1'b1;
                            res_id      = hit ? pix_id_reg : best_id_reg;
                            res_last    = 1'b1;
                            active_next = 1'b0;
                            win_w_next  = '0;
                            win_h_next  = '0;
                            row_next    = '0;
                            col_next    = '0;
                        end
                    end
                end
                default:
                begin
                    has_res = 1'b0;
                end
            endcase
        end
    end

    // hold the word while its result cannot be placed
    assign exec_go = busy_reg && (!has_res || out_free);

    always_comb
    begin
        busy_next = busy_reg;
        if (acc)
            busy_next = 1'b1;
        else if (exec_go)
            busy_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            view_left_reg   <= '0;
            view_bottom_reg <= '0;
            view_width_reg  <= VIEW_WIDTH_RST;
            view_height_reg <= VIEW_HEIGHT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_VIEW_LEFT:   view_left_reg   <= cfg_wdata[COORD_W-1:0];
                REG_VIEW_BOTTOM: view_bottom_reg <= cfg_wdata[COORD_W-1:0];
                REG_VIEW_WIDTH:  view_width_reg  <= cfg_wdata;
                REG_VIEW_HEIGHT: view_height_reg <= cfg_wdata;
                default:         view_left_reg   <= view_left_reg;
            endcase
        end
    end

    // word capture
    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            act_reg         <= s_tuser;
            id_reg          <= id_in;
            px_reg          <= s_tdata[S_PX_LO +: COORD_W];
            py_reg          <= s_tdata[S_PY_LO +: COORD_W];
            rad_reg         <= s_tdata[S_RAD_LO +: RAD_W];
            xid_reg         <= s_tdata[S_XID_LO +: XID_W];
            pix_id_reg      <= pix_in;
            alloc_row_reg   <= cand_pick[ROW_AW-1:0];
            alloc_found_reg <= cand_pick[ROW_SHIFT];
            sq_i_reg        <= DIST_W'(di_sq);
            sq_j_reg        <= DIST_W'(dj_sq);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            active_reg    <= 1'b0;
            win_w_reg     <= '0;
            win_h_reg     <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            best_dist_reg <= '1;
            best_id_reg   <= '0;
            skip_reg      <= '1;
            full_reg      <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            if (exec_go)
            begin
                active_reg    <= active_next;
                win_w_reg     <= win_w_next;
                win_h_reg     <= win_h_next;
                row_reg       <= row_next;
                col_reg       <= col_next;
                best_dist_reg <= best_dist_next;
                best_id_reg   <= best_id_next;
                skip_reg      <= skip_next;
                full_reg      <= full_next;
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (exec_go && has_res)
            m_valid_reg <= 1'b1;
        else if (m_tready)
            m_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (exec_go && has_res)
        begin
            out_data_reg <= {{(M_DATA_W - M_USED_W){1'b0}}, res_win.h, res_win.w,
                             res_win.y, res_win.x, res_ok, res_id};
            out_last_reg <= res_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

@@ rtl/ida_checker.sv @@
// port-level checks for the id allocator with nearest pick, bound to the top level
module ida_checker
    import ida_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata,
    input logic                m_tlast
);

    // one word in flight: ready drops right after an accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while previous word still in flight");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result word changed while stalled");

    // a pick answer carries no window and no success flag
    a_done_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tdata[M_WW_LO +: WIN_W] == '0 && !m_tdata[M_SUCCESS])
        else $error("pick answer with window or success set");

    // a nonzero window width comes with a nonzero window height
    a_win_pair: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[M_WW_LO +: WIN_W] != '0 |-> m_tdata[M_WH_LO +: WIN_W] != '0)
        else $error("window width without height");

endmodule

bind id_allocator_nearest_pick ida_checker u_ida_checker (.*);

@@ tb/ida_result_checker.sv @@
// result checker for the id allocator: watches all channels, predicts and compares
`timescale 1ns / 100ps
module ida_result_checker
    import ida_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [IDX_W-1:0]    cfg_index,
    input  logic [VIEW_W-1:0]   cfg_wdata,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic [ACT_W-1:0]    s_tuser,
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [M_DATA_W-1:0] m_tdata,
    input  logic                m_tlast,
    output int                  fail_count,
    output int                  pending
);

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic               ok;
        logic [COORD_W-1:0] wx;
        logic [COORD_W-1:0] wy;
        logic [WIN_W-1:0]   ww;
        logic [WIN_W-1:0]   wh;
        logic               done;
    } answer_t;

    answer_t answer_q[$];
    bit      id_map[ID_COUNT_DEF];
    int      win_w, win_h, row_cnt, col_cnt;
    int      best_dist, best_id, skip_id;
    int      view_l, view_b, view_w, view_h;
    int      fails = 0;

    function automatic void end_search();
        win_w   = 0;
        win_h   = 0;
        row_cnt = 0;
        col_cnt = 0;
    endfunction

    function automatic void reset_model();
        foreach (id_map[k])
            id_map[k] = 1'b0;
        end_search();
        best_dist = 16'hFFFF;
        best_id   = 0;
        skip_id   = -1;
        view_l    = 0;
        view_b    = 0;
        view_w    = int'(VIEW_WIDTH_RST);
        view_h    = int'(VIEW_HEIGHT_RST);
    endfunction

    // returns 1 when the word produces a result word
    function automatic bit compute_answer(input logic [ACT_W-1:0] act,
                                          input logic [S_DATA_W-1:0] d,
                                          output answer_t a);
        int r, x, y, w, h, rgt, tp, di, dj, px_dist, pid;
        bit found;
        a     = '0;
        found = 1'b0;
        if (act == ACT_ALLOC)
        begin
            // lowest free id, ids 0 and ID_COUNT-1 are never handed out
            for (int k = 1; k < ID_COUNT_DEF - 1; k++)
            begin
                if (!found && !id_map[k])
                begin
                    id_map[k] = 1'b1;
                    a.id      = ID_W'(k);
                    a.ok      = 1'b1;
                    found     = 1'b1;
                end
            end
            return 1'b1;
        end
        if (act == ACT_FREE)
        begin
            pid = int'(d[S_ID_LO +: ID_W]);
            if (pid < ID_COUNT_DEF && id_map[pid])
            begin
                id_map[pid] = 1'b0;
                a.ok        = 1'b1;
            end
            return 1'b1;
        end
        if (act == ACT_PICK)
        begin
            r = int'(d[S_RAD_LO +: RAD_W]);
            if (r > MAX_RADIUS_DEF)
                r = MAX_RADIUS_DEF;
            w   = 2 * r + 1;
            h   = w;
            x   = int'(d[S_PX_LO +: COORD_W]) - r;
            y   = int'(d[S_PY_LO +: COORD_W]) - r;
            rgt = view_l + view_w;
            tp  = view_b + view_h;
            if (x < view_l)
            begin
                w -= view_l - x;
                x  = view_l;
            end
            if (y < view_b)
            begin
                h -= view_b - y;
                y  = view_b;
            end
            if (x + w > rgt)
                w -= x + w - rgt;
            if (y + h > tp)
                h -= y + h - tp;
            if (w <= 0 || h <= 0)
            begin
                end_search();
                a.done = 1'b1;
                return 1'b1;
            end
            win_w     = w;
            win_h     = h;
            row_cnt   = 0;
            col_cnt   = 0;
            best_dist = 16'hFFFF;
            best_id   = 0;
            skip_id   = int'($signed(d[S_XID_LO +: XID_W]));
            a.wx      = COORD_W'(x);
            a.wy      = COORD_W'(y);
            a.ww      = WIN_W'(w);
            a.wh      = WIN_W'(h);
            return 1'b1;
        end
        // window pixel, ignored with no search running
        if (win_w == 0 || win_h == 0 || row_cnt >= win_h)
            return 1'b0;
        pid     = int'(d[S_PIX_LO +: ID_W]);
        di      = 2 * row_cnt - win_h;
        dj      = 2 * col_cnt - win_w;
        px_dist = di * di + dj * dj;
        if (px_dist < best_dist && id_map[pid] && pid != skip_id)
        begin
            best_dist = px_dist;
            best_id   = pid;
        end
        col_cnt++;
        if (col_cnt >= win_w)
        begin
            col_cnt = 0;
            row_cnt++;
            if (row_cnt >= win_h)
            begin
                end_search();
                a.id   = ID_W'(best_id);
                a.done = 1'b1;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s expected %0d actual %0d", name, want, got);
            fails++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        answer_t want, got;
        if (!rst_n)
        begin
            reset_model();
            answer_q.delete();
        end
        else
        begin
            // result side first: a word accepted now cannot answer at this edge
            if (m_tvalid && m_tready)
            begin
                if (answer_q.size() == 0)
                begin
                    $error("result word with no expected result pending");
                    fails++;
                end
                else
                begin
                    want = answer_q.pop_front();
                    check_field("result_id", want.id, m_tdata[0 +: ID_W]);
                    check_field("success", want.ok, m_tdata[M_SUCCESS]);
                    check_field("window_x", want.wx, m_tdata[M_WX_LO +: COORD_W]);
                    check_field("window_y", want.wy, m_tdata[M_WY_LO +: COORD_W]);
                    check_field("window_w", want.ww, m_tdata[M_WW_LO +: WIN_W]);
                    check_field("window_h", want.wh, m_tdata[M_WH_LO +: WIN_W]);
                    check_field("zero fill", 0, m_tdata[M_DATA_W-1:M_USED_W]);
                    check_field("pick_done", want.done, m_tlast);
                end
            end
            if (s_tvalid && s_tready)
            begin
                if (compute_answer(s_tuser, s_tdata, got))
                    answer_q.push_back(got);
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_VIEW_LEFT:   view_l = int'(cfg_wdata[COORD_W-1:0]);
                    REG_VIEW_BOTTOM: view_b = int'(cfg_wdata[COORD_W-1:0]);
                    REG_VIEW_WIDTH:  view_w = int'(cfg_wdata);
                    REG_VIEW_HEIGHT: view_h = int'(cfg_wdata);
                    default: ;
                endcase
            end
        end
        pending    <= answer_q.size();
        fail_count <= fails;
    end

endmodule

@@ tb/tb_id_allocator_nearest_pick.sv @@
// testbench top for the id allocator with nearest pick: stimulus and verdict
`timescale 1ns / 100ps
module tb_id_allocator_nearest_pick;
    import ida_pkg::*;

    localparam int CYCLE_LIMIT = 1500000;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                cfg_we    = 1'b0;
    logic [IDX_W-1:0]    cfg_index = REG_VIEW_LEFT;
    logic [VIEW_W-1:0]   cfg_wdata = '0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    // id_to_free, point_x, point_y, radius, excluded_id, pixel_word, zero fill
    logic [S_DATA_W-1:0] s_tdata   = '0;
    // action
    logic [ACT_W-1:0]    s_tuser   = ACT_ALLOC;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    // result_id, success, window_x, window_y, window_w, window_h, zero fill
    logic [M_DATA_W-1:0] m_tdata;
    // pick_done
    logic                m_tlast;

    int fail_count;
    int pending;
    int words_sent  = 0;
    int cycle_count = 0;

    // quiet: no idling on either side; squeeze_req: receiver long hold-off
    bit quiet       = 1'b0;
    bit squeeze_req = 1'b0;

    // shadow of the viewport, used to size the pixel streams and to place pick centres
    int vl = 0;
    int vb = 0;
    int vw = 1920;
    int vh = 1080;

    id_allocator_nearest_pick DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    ida_result_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // hard stop in case the handshake hangs
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // mostly short gaps, a few long ones, none at all in quiet stretches
    function automatic int idle_gap();
        int roll;
        if (quiet)
            return 0;
        roll = $urandom_range(99, 0);
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(3, 1);
        return $urandom_range(25, 4);
    endfunction

    // result side: random stalls, plus one long hold when asked
    initial
    begin : receiver
        int g;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (squeeze_req)
            begin
                m_tready <= 1'b0;
                repeat (400) @(posedge clk);
                squeeze_req = 1'b0;
                m_tready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                g = idle_gap();
                if (g > 0)
                begin
                    m_tready <= 1'b0;
                    repeat (g) @(posedge clk);
                end
                m_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // every field random, zero fill kept clear; callers overwrite what matters
    function automatic logic [S_DATA_W-1:0] rand_fields();
        logic [S_DATA_W-1:0] d;
        d = '0;
        d[S_ID_LO  +: ID_W]    = ID_W'($urandom);
        d[S_PX_LO  +: COORD_W] = COORD_W'($urandom);
        d[S_PY_LO  +: COORD_W] = COORD_W'($urandom);
        d[S_RAD_LO +: RAD_W]   = RAD_W'($urandom);
        d[S_XID_LO +: XID_W]   = XID_W'($urandom);
        d[S_PIX_LO +: PIX_W]   = $urandom;
        return d;
    endfunction

    // offer one word after a random gap, return at the edge it is taken
    task automatic put_word(input logic [ACT_W-1:0] act, input logic [S_DATA_W-1:0] d);
        int g;
        g = idle_gap();
        if (g > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= d;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        words_sent++;
    endtask

    task automatic send_alloc();
        put_word(ACT_ALLOC, rand_fields());
    endtask

    task automatic send_free(input int id);
        logic [S_DATA_W-1:0] d;
        d = rand_fields();
        d[S_ID_LO +: ID_W] = ID_W'(id);
        put_word(ACT_FREE, d);
    endtask

    task automatic send_pick(input int px, input int py, input int r, input int xid);
        logic [S_DATA_W-1:0] d;
        d = rand_fields();
        d[S_PX_LO  +: COORD_W] = COORD_W'(px);
        d[S_PY_LO  +: COORD_W] = COORD_W'(py);
        d[S_RAD_LO +: RAD_W]   = RAD_W'(r);
        d[S_XID_LO +: XID_W]   = XID_W'(xid);
        put_word(ACT_PICK, d);
    endtask

    task automatic send_pixel(input logic [PIX_W-1:0] px_word);
        logic [S_DATA_W-1:0] d;
        d = rand_fields();
        d[S_PIX_LO +: PIX_W] = px_word;
        put_word(ACT_PIXEL, d);
    endtask

    // low ids are the ones most likely held
    function automatic int free_target();
        int roll;
        roll = $urandom_range(99, 0);
        if (roll < 50)
            return $urandom_range(48, 1);
        if (roll < 60)
            return $urandom_range(1, 0) ? 255 : 0;
        return $urandom_range(255, 0);
    endfunction

    function automatic logic [ID_W-1:0] pixel_id();
        int roll;
        roll = $urandom_range(99, 0);
        if (roll < 60)
            return ID_W'($urandom_range(48, 1));
        if (roll < 70)
            return '0;
        if (roll < 80)
            return $urandom_range(1, 0) ? 8'd255 : 8'd254;
        return ID_W'($urandom);
    endfunction

    function automatic int pick_excluded();
        int roll;
        roll = $urandom_range(99, 0);
        if (roll < 50)
            return -1;
        if (roll < 75)
            return $urandom_range(48, 1);
        return $urandom_range(511, 0);
    endfunction

    // small windows keep the pixel streams short
    function automatic int pick_radius();
        int roll;
        roll = $urandom_range(99, 0);
        if (roll < 70)
            return $urandom_range(3, 0);
        if (roll < 92)
            return $urandom_range(8, 4);
        return $urandom_range(MAX_RADIUS_DEF, 9);
    endfunction

    // centre mostly near the viewport so the clipping edges get hit
    function automatic int pick_coord(input int lo, input int size, input int r);
        int a, b;
        if ($urandom_range(99, 0) < 15)
            return $urandom_range(8191, 0);
        a = lo - r - 3;
        b = lo + size + r + 3;
        if (a < 0)
            a = 0;
        if (b > 8191)
            b = 8191;
        if (a > b)
            a = b;
        return $urandom_range(b, a);
    endfunction

    // pixel count of the clipped window, right and top edges at origin plus size
    function automatic int window_area(input int px, input int py, input int r);
        int x0, x1, y0, y1;
        x0 = px - r;
        x1 = px + r + 1;
        y0 = py - r;
        y1 = py + r + 1;
        if (x0 < vl)
            x0 = vl;
        if (y0 < vb)
            y0 = vb;
        if (x1 > vl + vw)
            x1 = vl + vw;
        if (y1 > vb + vh)
            y1 = vb + vh;
        if (x1 <= x0 || y1 <= y0)
            return 0;
        return (x1 - x0) * (y1 - y0);
    endfunction

    // pick followed by up to stop pixels, a few map updates mixed in
    task automatic run_pick(input int px, input int py, input int r, input int xid,
                            input int stop);
        int n;
        n = window_area(px, py, r);
        if (stop < n)
            n = stop;
        send_pick(px, py, r, xid);
        for (int k = 0; k < n; k++)
        begin
            if ($urandom_range(99, 0) < 3)
            begin
                if ($urandom_range(1, 0))
                    send_alloc();
                else
                    send_free(free_target());
            end
            send_pixel({24'($urandom), pixel_id()});
        end
    endtask

    task automatic random_traffic(input int quota);
        int goal, roll, r, px, py, n, stop;
        goal = words_sent + quota;
        while (words_sent < goal)
        begin
            roll = $urandom_range(99, 0);
            if (roll < 20)
                send_alloc();
            else if (roll < 35)
                send_free(free_target());
            else if (roll < 90)
            begin
                r    = pick_radius();
                px   = pick_coord(vl, vw, r);
                py   = pick_coord(vb, vh, r);
                n    = window_area(px, py, r);
                stop = n;
                // huge windows and some others are cut short by the next pick
                if (n > 200 || roll >= 82)
                    stop = $urandom_range(n > 30 ? 30 : n, 0);
                run_pick(px, py, r, pick_excluded(), stop);
            end
            else
            begin
                // stray pixels, ignored or fed into an unfinished search
                repeat ($urandom_range(3, 1))
                    send_pixel($urandom);
            end
        end
    endtask

    // all four viewport registers, one write per cycle
    task automatic set_view(input int l, input int b, input int w, input int h);
        cfg_we    <= 1'b1;
        cfg_index <= REG_VIEW_LEFT;
        cfg_wdata <= VIEW_W'(l);
        @(posedge clk);
        cfg_index <= REG_VIEW_BOTTOM;
        cfg_wdata <= VIEW_W'(b);
        @(posedge clk);
        cfg_index <= REG_VIEW_WIDTH;
        cfg_wdata <= VIEW_W'(w);
        @(posedge clk);
        cfg_index <= REG_VIEW_HEIGHT;
        cfg_wdata <= VIEW_W'(h);
        @(posedge clk);
        cfg_we <= 1'b0;
        vl = l;
        vb = b;
        vw = w;
        vh = h;
    endtask

    // drop valid, wait for every answer, then let a trailing pixel drain
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    initial
    begin : stimulus
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // map basics: free of a clear id, lowest-first allocate, double free, id 255
        send_free(0);
        send_alloc();
        send_alloc();
        send_free(1);
        send_free(1);
        send_alloc();
        send_free(255);
        // pixel with no search running is dropped
        send_pixel(32'hFFFF_FF02);
        // corner window clipped to 2x2, ties keep the earlier hit
        send_pick(0, 0, 1, -1);
        send_pixel(32'h0000_0001);
        send_pixel(32'hFFFF_FF02);
        send_pixel(32'hABCD_EF01);
        send_pixel(32'h1234_5602);
        // window fully outside the viewport
        send_pick(8191, 8191, 5, -1);
        // single pixel holding the excluded id
        send_pick(5, 5, 0, 2);
        send_pixel(32'h0000_0002);
        // full 127x127 window, abandoned by a new pick
        send_pick(100, 100, MAX_RADIUS_DEF, -1);
        send_pixel(32'h0000_0001);
        send_pick(10, 10, 0, 255);
        send_pixel(32'h0000_0001);
        // right and top edges sit at origin plus size
        send_pick(1920, 1080, 1, -1);
        send_pixel(32'h8000_0001);

        random_traffic(180);
        settle();

        // back-to-back allocates against a stalled receiver fill the map past full
        quiet       = 1'b1;
        squeeze_req = 1'b1;
        repeat (260) send_alloc();
        quiet = 1'b0;
        for (int k = 1; k < 255; k += 2)
            send_free(k);
        random_traffic(150);
        settle();

        // largest viewport
        set_view(0, 0, 8192, 8192);
        random_traffic(300);
        settle();

        // empty viewport at the far corner: every pick is empty
        set_view(8191, 8191, 0, 0);
        random_traffic(60);
        settle();

        // far corner with maximal size, no idling on either side
        set_view(8191, 8191, 8192, 8192);
        quiet = 1'b1;
        random_traffic(150);
        quiet = 1'b0;
        settle();

        // small viewport, heavy clipping on all four sides
        set_view(100, 50, 40, 30);
        random_traffic(300);
        settle();

        repeat (3)
        begin
            set_view($urandom_range(8191, 0), $urandom_range(8191, 0),
                     $urandom_range(8192, 0), $urandom_range(8192, 0));
            random_traffic(100);
            settle();
        end

        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
